// File: src/mm3_pkg.sv
// Shared types, constants and helper functions for the MurmurHash3 x86_32 stream hasher.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps
`default_nettype none

package mm3_pkg;

    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [31:0] C1     = 32'hcc9e2d51;
    localparam logic [31:0] C2     = 32'h1b873593;
    localparam logic [31:0] H_ADD  = 32'he6546b64;
    localparam logic [31:0] F1     = 32'h85ebca6b;
    localparam logic [31:0] F2     = 32'hc2b2ae35;

    localparam logic [2:0] CNT_FULL = 3'd4;
    localparam logic [2:0] CNT_NONE = 3'd0;

    // Word as queued for the back end: tail bytes already masked off.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX2,
        ST_UPD,
        ST_FIN1,
        ST_FIN2,
        ST_OUT
    } t_bstate;

    function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
        logic [31:0] m;
        case (cnt)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

endpackage

`default_nettype wire

// File: src/mm3_front.sv
// Front end: accepts stream transfers, saturates the byte count, masks tail bytes
// and holds the classified words in a short queue. Uses mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm3_front import mm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last,
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  wire logic        i_q_pop
);

    t_item              r_mem [QDEPTH];
    logic [QA_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    t_item              w_item;
    logic               w_push;
    logic               w_pop;
    logic [2:0]         w_cnt;

    // Non-last words always count as full; counts above four saturate.
    always_comb begin
        if (!i_last || i_byte_count > CNT_FULL) begin
            w_cnt = CNT_FULL;
        end else begin
            w_cnt = i_byte_count;
        end
        w_item.word = i_word & byte_mask(w_cnt);
        w_item.cnt  = w_cnt;
        w_item.last = i_last;
    end

    assign o_ready   = (r_count != QCNT_W'(QDEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QA_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QA_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/mm3_back.sv
// Back end: sequencer that mixes one queued word at a time into the running hash,
// runs the avalanche finalizer on the last word and holds the result register. Uses mm3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mm3_back import mm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_q_valid,
    input  wire t_item       i_q_item,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_out_data
);

    t_bstate     r_state, n_state;
    logic [31:0] r_seed;
    logic [31:0] r_k;
    logic [31:0] r_hash;
    logic [31:0] r_len;
    logic [2:0]  r_cnt;
    logic        r_last;
    logic        r_in_key;
    logic [31:0] r_out;
    logic        r_out_valid;
    logic        w_load_out;
    logic [31:0] w_upd;
    logic [31:0] w_fin1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_MIX2;
                end
            end
            ST_MIX2: n_state = ST_UPD;
            ST_UPD:  n_state = r_last ? ST_FIN1 : ST_IDLE;
            ST_FIN1: n_state = ST_FIN2;
            ST_FIN2: n_state = ST_OUT;
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hash update for one word, plus the first finalizer mix; the tail skips the rotate and multiply-add.
    always_comb begin
        w_upd = r_hash;
        if (r_cnt != CNT_NONE) begin
            w_upd = w_upd ^ r_k;
        end
        if (r_cnt == CNT_FULL) begin
            w_upd = rotl13(w_upd);
            w_upd = (w_upd << 2) + w_upd + H_ADD;
        end
        w_fin1 = r_hash ^ r_len;
        w_fin1 = w_fin1 ^ (w_fin1 >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= '0;
            r_in_key <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_seed <= i_cfg_data;
            end
            if (r_state == ST_IDLE && i_q_valid) begin
                r_in_key <= 1'b1;
            end else if (r_state == ST_UPD && r_last) begin
                r_in_key <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_k    <= i_q_item.word * C1;
                    r_cnt  <= i_q_item.cnt;
                    r_last <= i_q_item.last;
                    if (!r_in_key) begin
                        r_hash <= r_seed;
                        r_len  <= '0;
                    end
                end
            end
            ST_MIX2: r_k <= rotl15(r_k) * C2;
            ST_UPD: begin
                r_hash <= w_upd;
                r_len  <= r_len + {29'd0, r_cnt};
            end
            ST_FIN1: r_hash <= w_fin1 * F1;
            ST_FIN2: r_hash <= (r_hash ^ (r_hash >> 13)) * F2;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_hash ^ (r_hash >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: src/murmur3_32_hash_stream.sv
// MurmurHash3 x86_32 over a stream of little-endian key words; instantiates mm3_front
// and mm3_back, uses mm3_pkg. The back-end sequencer with its registered multiplier steps
// sets the rate, taking one queued word at a time: each word passes the idle (pop), second-mix
// and update states; a last word then passes the finalizer states FIN1 and FIN2 and the state
// that loads the output register (waiting there while a previous result is still held).
// The front queue holds 4 words so input transfers continue while the back end works.
// Synchronous active-low reset clears the queue, sequencer, output valid and seed (to 0).
`timescale 1ns / 1ps
`default_nettype none

module murmur3_32_hash_stream import mm3_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [31:0] word_data, [34:32] byte_count, rest 0
    input  wire logic        s_axis_tlast,   // last_word
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] hash_value
);

    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    assign o_cfg_ready = 1'b1;

    mm3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_word       (s_axis_tdata[31:0]),
        .i_byte_count (s_axis_tdata[34:32]),
        .i_last       (s_axis_tlast),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    mm3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: verif/tb_murmur3_32_hash_stream.sv
// Self-checking testbench for murmur3_32_hash_stream: directed and random keys over the word stream,
// with a scoreboard class holding a behavioral MurmurHash3 x86_32 model. Needs only the RTL.
`timescale 1ns / 1ps

module tb_murmur3_32_hash_stream;

    localparam logic [31:0] MIX_C1    = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] HASH_ADD  = 32'he6546b64;
    localparam logic [31:0] AVAL_M1   = 32'h85ebca6b;
    localparam logic [31:0] AVAL_M2   = 32'hc2b2ae35;
    localparam logic [2:0]  BYTES_FULL = 3'd4;
    localparam logic [2:0]  BYTES_NONE = 3'd0;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          DRAIN_LIMIT   = 20000;
    localparam int          PHASE_WORDS   = 400;

    class hash_scoreboard;
        logic [31:0] seed;
        logic [31:0] run_hash;
        logic [31:0] key_len;
        bit          in_key;
        logic [31:0] pending_hashes[$];
        int          errors;
        int          words_seen;
        int          hashes_checked;

        function new();
            seed = '0;
            run_hash = '0;
            key_len = '0;
            in_key = 1'b0;
            errors = 0;
            words_seen = 0;
            hashes_checked = 0;
        endfunction

        function logic [31:0] rol(input logic [31:0] v, input int r);
            return (v << r) | (v >> (32 - r));
        endfunction

        function logic [31:0] mix_block(input logic [31:0] k);
            logic [31:0] t;
            t = k * MIX_C1;
            t = rol(t, 15);
            t = t * MIX_C2;
            return t;
        endfunction

        function logic [31:0] finalize(input logic [31:0] h);
            logic [31:0] t;
            t = h ^ (h >> 16);
            t = t * AVAL_M1;
            t = t ^ (t >> 13);
            t = t * AVAL_M2;
            t = t ^ (t >> 16);
            return t;
        endfunction

        // One accepted word; pushes the expected hash when it closes a key.
        function void note_word(input logic [31:0] w, input logic [2:0] cnt, input bit last);
            logic [2:0]  n;
            logic [31:0] keep;
            words_seen++;
            if (!in_key) begin
                run_hash = seed;
                key_len = '0;
                in_key = 1'b1;
            end
            n = (!last || cnt > BYTES_FULL) ? BYTES_FULL : cnt;
            if (n == BYTES_FULL) begin
                run_hash = run_hash ^ mix_block(w);
                run_hash = rol(run_hash, 13);
                run_hash = run_hash * 32'd5 + HASH_ADD;
            end else if (n != BYTES_NONE) begin
                keep = (32'd1 << (8 * n)) - 32'd1;
                run_hash = run_hash ^ mix_block(w & keep);
            end
            key_len = key_len + 32'(n);
            if (last) begin
                pending_hashes.push_back(finalize(run_hash ^ key_len));
                in_key = 1'b0;
            end
        endfunction

        function void check_hash(input logic [31:0] actual);
            logic [31:0] want;
            if (pending_hashes.size() == 0) begin
                errors++;
                $display("%0t: unexpected hash transfer, actual %08h", $time, actual);
                return;
            end
            want = pending_hashes.pop_front();
            hashes_checked++;
            if (actual !== want) begin
                errors++;
                $display("%0t: hash mismatch, expected %08h actual %08h", $time, want, actual);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // [31:0] word_data, [34:32] byte_count, rest 0
    logic        s_axis_tlast = 1'b0;  // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] hash_value

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int seeds_written = 0;

    hash_scoreboard sb = new();

    murmur3_32_hash_stream uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: check each transfer, then pick next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_hash(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin
        #1_000_000;
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input bit last);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, cnt, w};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(w, cnt, last);
    endtask

    // Hold the sender until every pending hash is out or the wait limit is hit, then let it settle.
    task automatic drain_block();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.seed = v;
        seeds_written++;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short keys, some long; count fields span all eight codes.
    task automatic send_key();
        int n_words;
        n_words = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        for (int i = 0; i < n_words; i++)
            send_word(pick_word(), 3'($urandom_range(7)), i == n_words - 1);
    endtask

    initial begin
        logic [31:0] phase_seed [4];
        int target;
        phase_seed[0] = 32'hffff_ffff;
        phase_seed[1] = $urandom;
        phase_seed[2] = 32'h0000_0000;
        phase_seed[3] = $urandom;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty key, masked tails, saturated counts, ignored counts mid-key.
        send_word(32'h1234_5678, BYTES_NONE, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 1'b1);
        send_word(32'hffff_ffff, 3'd3, 1'b1);
        send_word(32'h0000_0000, BYTES_FULL, 1'b1);
        send_word(32'hffff_ffff, BYTES_FULL, 1'b1);
        send_word(32'ha5a5_5a5a, 3'd5, 1'b1);
        send_word(32'h0123_4567, 3'd7, 1'b1);
        send_word(32'h0000_0000, BYTES_NONE, 1'b0);
        send_word(32'hffff_ffff, 3'd7, 1'b0);
        send_word($urandom, 3'd2, 1'b0);
        send_word(32'hdead_beef, 3'd2, 1'b1);
        // seed change in the middle of a key applies from the next key on
        send_word(32'hcafe_f00d, BYTES_FULL, 1'b0);
        drain_block();
        write_seed(32'h9747_b28c);
        send_word(32'h6b6e_6f77, 3'd3, 1'b1);
        send_word(32'h0000_0000, BYTES_NONE, 1'b1);
        send_word(32'h7856_3412, BYTES_FULL, 1'b1);

        for (int p = 0; p < 4; p++) begin
            drain_block();
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            write_seed(phase_seed[p]);
            target = sb.words_seen + PHASE_WORDS;
            while (sb.words_seen < target)
                send_key();
        end

        drain_block();
        $display("Streamed %0d key words, checked %0d hashes under %0d seed settings.",
                 sb.words_seen, sb.hashes_checked, seeds_written + 1);
        $display("Covered empty and partial tails, saturated counts and four flow-control mixes.");
        if (sb.pending_hashes.size() != 0)
            $display("%0t: %0d expected hashes never arrived", $time, sb.pending_hashes.size());
        if (sb.errors == 0 && sb.pending_hashes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
src/mm3_pkg.sv
src/mm3_front.sv
src/mm3_back.sv
src/murmur3_32_hash_stream.sv
verif/tb_murmur3_32_hash_stream.sv
